@@ src/cid_pkg.sv @@
package cid_pkg;

	localparam int OffsetWidthDefault = 32;
	localparam int QueueDepth = 4;
	localparam int CheckWidth = 35;

	localparam logic [7:0] OP_PREFIX   = 8'hFE;
	localparam logic [7:0] OP_SWITCH   = 8'h45;
	localparam logic [7:0] OP_JMP      = 8'h27;
	localparam logic [7:0] OP_RET      = 8'h2A;
	localparam logic [7:0] OP2_TAIL    = 8'h14;
	localparam logic [7:0] OP2_LOCALLOC = 8'h0F;

	localparam logic [2:0] KIND_PLAIN    = 3'd0;
	localparam logic [2:0] KIND_RET      = 3'd1;
	localparam logic [2:0] KIND_SHORT_BR = 3'd2;
	localparam logic [2:0] KIND_LONG_BR  = 3'd3;
	localparam logic [2:0] KIND_SW_HDR   = 3'd4;
	localparam logic [2:0] KIND_SW_TGT   = 3'd5;
	localparam logic [2:0] KIND_TWO_BYTE = 3'd6;
	localparam logic [2:0] KIND_STATUS   = 3'd7;

	localparam logic [1:0] FAIL_NONE      = 2'd0;
	localparam logic [1:0] FAIL_UNKNOWN   = 2'd1;
	localparam logic [1:0] FAIL_TRUNCATED = 2'd2;

	localparam logic [2:0] PH_OPCODE   = 3'd0;
	localparam logic [2:0] PH_SECOND   = 3'd1;
	localparam logic [2:0] PH_OPERAND  = 3'd2;
	localparam logic [2:0] PH_SWCOUNT  = 3'd3;
	localparam logic [2:0] PH_SWTARGET = 3'd4;
	localparam logic [2:0] PH_DEAD     = 3'd5;

	// one decoded word waiting for target and length work
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] start;
		logic [7:0]  first_op;
		logic [7:0]  second_op;
		logic [31:0] accum;
		logic [31:0] sw_base;
		logic        unsafe;
		logic        last;
		logic [1:0]  fail;
	} dec_rec_t;

	// bit 4 set means unknown opcode
	function automatic logic [4:0] len_one(input logic [7:0] op);
		logic [4:0] r;
		r = 5'h10;
		if (op inside {[8'h00:8'h0D], [8'h14:8'h1E], 8'h25, 8'h26, 8'h2A, [8'h46:8'h6E],
				8'h76, 8'h7A, [8'h82:8'h8B], 8'h8E, [8'h90:8'hA2], [8'hB3:8'hBA],
				8'hC3, 8'hCB, [8'hD1:8'hDC], 8'hDF, 8'hE0})
			r = 5'd0;
		else if (op inside {[8'h0E:8'h13], 8'h1F, [8'h2B:8'h37], 8'hDE})
			r = 5'd1;
		else if (op inside {8'h20, 8'h22, 8'h27, 8'h28, 8'h29, [8'h38:8'h44],
				[8'h6F:8'h75], 8'h79, [8'h7B:8'h81], 8'h8C, 8'h8D, 8'h8F,
				[8'hA3:8'hA5], 8'hC2, 8'hC6, 8'hD0, 8'hDD})
			r = 5'd4;
		else if (op == 8'h21 || op == 8'h23)
			r = 5'd8;
		return r;
	endfunction

	function automatic logic [4:0] len_two(input logic [7:0] op);
		logic [4:0] r;
		r = 5'h10;
		if (op inside {[8'h00:8'h05], 8'h0F, 8'h11, 8'h13, 8'h14, 8'h17, 8'h18, 8'h1A,
				8'h1D, 8'h1E})
			r = 5'd0;
		else if (op == 8'h12 || op == 8'h19)
			r = 5'd1;
		else if (op inside {[8'h09:8'h0E]})
			r = 5'd2;
		else if (op inside {8'h06, 8'h07, 8'h15, 8'h16, 8'h1C})
			r = 5'd4;
		return r;
	endfunction

	function automatic logic [2:0] kind_of(input logic [7:0] first);
		logic [2:0] k;
		if (first == OP_PREFIX)
			k = KIND_TWO_BYTE;
		else if (first inside {[8'h2B:8'h37], 8'hDE})
			k = KIND_SHORT_BR;
		else if (first inside {[8'h38:8'h44], 8'hDD})
			k = KIND_LONG_BR;
		else if (first == OP_RET)
			k = KIND_RET;
		else
			k = KIND_PLAIN;
		return k;
	endfunction

endpackage

@@ src/cil_instruction_boundary_decoder_unit.sv @@
// Bytecode boundary decoder: takes one code byte per cycle and reports each instruction as
// its last byte arrives (a switch as a header word and a word per target), one word per
// cycle sustained unless the output stalls. The front end classifies bytes through the
// opcode length tables and tracks the decode phase; a four-word queue separates it from the
// back end, which works out lengths and branch targets into the output register. Input is
// stalled only while the queue is full. Write body_size while idle, before the body.
module cil_instruction_boundary_decoder_unit import cid_pkg::*; #(
	parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  item_kind,
	output logic [31:0] instr_offset,
	output logic [7:0]  first_op,
	output logic [7:0]  second_op,
	output logic [31:0] instr_length,
	output logic [31:0] jump_target,
	output logic        unsafe_seen,
	output logic        body_end,
	output logic [1:0]  fail_code
);
	logic     push, full, empty, pop;
	dec_rec_t push_rec, head_rec;

	assign in_stall = full;

	cid_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall, .code_byte,
		.push, .push_rec
	);

	cid_queue u_queue (
		.clk, .arst_n, .push, .push_rec, .full, .empty, .pop, .head_rec
	);

	cid_back #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_back (
		.clk, .arst_n, .q_empty(empty), .head_rec, .pop, .out_valid, .out_stall,
		.item_kind, .instr_offset, .first_op, .second_op, .instr_length, .jump_target,
		.unsafe_seen, .body_end, .fail_code
	);

endmodule

@@ src/cid_front.sv @@
module cid_front import cid_pkg::*; #(
	parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  code_byte,
	output logic        push,
	output dec_rec_t    push_rec
);
	localparam int OW = OFFSET_WIDTH;

	logic [31:0]   body_size_q;
	logic [OW-1:0] pos_q, start_q, sw_base_q;
	logic [2:0]    phase_q;
	logic [3:0]    left_q;
	logic [7:0]    first_q, second_q;
	logic [31:0]   accum_q, sw_left_q;
	logic [1:0]    err_q;
	logic          unsafe_q;

	logic [OW-1:0] start_n, sw_base_n;
	logic [2:0]    phase_n;
	logic [3:0]    left_n;
	logic [7:0]    first_n, second_n;
	logic [31:0]   accum_n, sw_left_n, acc_sh, rec_accum;
	logic [1:0]    err_n;
	logic          unsafe_n, have, last, active;
	logic [2:0]    kind;
	logic [4:0]    l1, l2;
	logic [CheckWidth-1:0] size_w, pos_w, start_w, base_w;

	assign size_w = CheckWidth'(body_size_q[OW-1:0]);
	assign pos_w = CheckWidth'(pos_q);
	assign start_w = CheckWidth'(start_q);
	assign active = in_valid && !in_stall && (pos_w < size_w);
	assign last = (pos_w + CheckWidth'(1)) == size_w;
	assign acc_sh = {code_byte, accum_q[31:8]};
	assign l1 = len_one(code_byte);
	assign l2 = len_two(code_byte);
	assign base_w = start_w + CheckWidth'(5) + {1'b0, acc_sh, 2'b00};

	always_comb begin
		start_n = start_q;
		sw_base_n = sw_base_q;
		phase_n = phase_q;
		left_n = left_q;
		first_n = first_q;
		second_n = second_q;
		accum_n = accum_q;
		sw_left_n = sw_left_q;
		err_n = err_q;
		unsafe_n = unsafe_q;
		have = 1'b0;
		kind = KIND_STATUS;
		rec_accum = '0;
		case (phase_q)
			PH_OPCODE: begin
				start_n = pos_q;
				first_n = code_byte;
				second_n = '0;
				accum_n = '0;
				if (code_byte == OP_PREFIX) begin
					if (pos_w + CheckWidth'(2) > size_w) begin
						err_n = FAIL_TRUNCATED;
						phase_n = PH_DEAD;
					end else
						phase_n = PH_SECOND;
				end else if (code_byte == OP_SWITCH) begin
					if (pos_w + CheckWidth'(5) > size_w) begin
						err_n = FAIL_TRUNCATED;
						phase_n = PH_DEAD;
					end else begin
						phase_n = PH_SWCOUNT;
						left_n = 4'd4;
					end
				end else if (l1[4]) begin
					err_n = FAIL_UNKNOWN;
					phase_n = PH_DEAD;
				end else begin
					if (code_byte == OP_JMP)
						unsafe_n = 1'b1;
					if (pos_w + CheckWidth'(1) + CheckWidth'(l1[3:0]) > size_w) begin
						err_n = FAIL_TRUNCATED;
						phase_n = PH_DEAD;
					end else if (l1[3:0] == 4'd0) begin
						have = 1'b1;
						kind = kind_of(code_byte);
					end else begin
						phase_n = PH_OPERAND;
						left_n = l1[3:0];
					end
				end
			end
			PH_SECOND: begin
				second_n = code_byte;
				if (l2[4]) begin
					err_n = FAIL_UNKNOWN;
					phase_n = PH_DEAD;
				end else begin
					if (code_byte == OP2_TAIL || code_byte == OP2_LOCALLOC)
						unsafe_n = 1'b1;
					if (start_w + CheckWidth'(2) + CheckWidth'(l2[3:0]) > size_w) begin
						err_n = FAIL_TRUNCATED;
						phase_n = PH_DEAD;
					end else if (l2[3:0] == 4'd0) begin
						have = 1'b1;
						kind = KIND_TWO_BYTE;
						phase_n = PH_OPCODE;
					end else begin
						phase_n = PH_OPERAND;
						left_n = l2[3:0];
					end
				end
			end
			PH_OPERAND: begin
				accum_n = acc_sh;
				left_n = left_q - 4'd1;
				if (left_n == 4'd0) begin
					have = 1'b1;
					kind = kind_of(first_q);
					rec_accum = acc_sh;
					phase_n = PH_OPCODE;
				end
			end
			PH_SWCOUNT: begin
				accum_n = acc_sh;
				left_n = left_q - 4'd1;
				if (left_n == 4'd0) begin
					if (base_w > size_w) begin
						err_n = FAIL_TRUNCATED;
						phase_n = PH_DEAD;
					end else begin
						sw_left_n = acc_sh;
						sw_base_n = base_w[OW-1:0];
						have = 1'b1;
						kind = KIND_SW_HDR;
						accum_n = '0;
						left_n = 4'd4;
						phase_n = (acc_sh == '0) ? PH_OPCODE : PH_SWTARGET;
					end
				end
			end
			PH_SWTARGET: begin
				accum_n = acc_sh;
				left_n = left_q - 4'd1;
				if (left_n == 4'd0) begin
					have = 1'b1;
					kind = KIND_SW_TGT;
					rec_accum = acc_sh;
					accum_n = '0;
					sw_left_n = sw_left_q - 32'd1;
					left_n = 4'd4;
					if (sw_left_n == '0)
						phase_n = PH_OPCODE;
				end
			end
			default: begin
			end
		endcase
		// body ends inside an instruction
		if (last && phase_n != PH_OPCODE && phase_n != PH_DEAD) begin
			err_n = FAIL_TRUNCATED;
			phase_n = PH_DEAD;
		end
	end

	assign push = active && (have || last);

	always_comb begin
		push_rec.kind = have ? kind : KIND_STATUS;
		push_rec.start = have ? 32'(start_n) : '0;
		push_rec.first_op = have ? first_n : '0;
		push_rec.second_op = have ? second_n : '0;
		push_rec.accum = rec_accum;
		push_rec.sw_base = 32'(sw_base_n);
		push_rec.unsafe = unsafe_n;
		push_rec.last = last;
		push_rec.fail = last ? err_n : FAIL_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			body_size_q <= '0;
		else if (cfg_wr_en)
			body_size_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			start_q <= '0;
			sw_base_q <= '0;
			phase_q <= PH_OPCODE;
			left_q <= '0;
			first_q <= '0;
			second_q <= '0;
			accum_q <= '0;
			sw_left_q <= '0;
			err_q <= FAIL_NONE;
			unsafe_q <= 1'b0;
		end else if (active) begin
			pos_q <= pos_q + OW'(1);
			start_q <= start_n;
			sw_base_q <= sw_base_n;
			phase_q <= phase_n;
			left_q <= left_n;
			first_q <= first_n;
			second_q <= second_n;
			accum_q <= accum_n;
			sw_left_q <= sw_left_n;
			err_q <= err_n;
			unsafe_q <= unsafe_n;
		end
	end

endmodule

@@ src/cid_queue.sv @@
module cid_queue import cid_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  dec_rec_t push_rec,
	output logic     full,
	output logic     empty,
	input  logic     pop,
	output dec_rec_t head_rec
);
	localparam int AW = $clog2(QueueDepth);

	dec_rec_t        entry_q [QueueDepth];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push, do_pop;

	assign full = count_q == (AW+1)'(QueueDepth);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			count_q <= count_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

@@ src/cid_back.sv @@
module cid_back import cid_pkg::*; #(
	parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  dec_rec_t    head_rec,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  item_kind,
	output logic [31:0] instr_offset,
	output logic [7:0]  first_op,
	output logic [7:0]  second_op,
	output logic [31:0] instr_length,
	output logic [31:0] jump_target,
	output logic        unsafe_seen,
	output logic        body_end,
	output logic [1:0]  fail_code
);
	localparam int OW = OFFSET_WIDTH;

	logic [OW-1:0] start, sw_base, len, tgt;
	logic [4:0]    l1, l2;

	assign start = head_rec.start[OW-1:0];
	assign sw_base = head_rec.sw_base[OW-1:0];
	assign l1 = len_one(head_rec.first_op);
	assign l2 = len_two(head_rec.second_op);
	assign pop = !q_empty && (!out_valid || !out_stall);

	always_comb begin
		case (head_rec.kind)
			KIND_TWO_BYTE: len = OW'(2) + OW'(l2[3:0]);
			KIND_SW_HDR, KIND_SW_TGT: len = sw_base - start;
			KIND_STATUS: len = '0;
			default: len = OW'(1) + OW'(l1[3:0]);
		endcase
		case (head_rec.kind)
			KIND_SHORT_BR:
				tgt = start + OW'(2) + OW'({{24{head_rec.accum[31]}}, head_rec.accum[31:24]});
			KIND_LONG_BR: tgt = start + OW'(5) + head_rec.accum[OW-1:0];
			KIND_SW_TGT: tgt = sw_base + head_rec.accum[OW-1:0];
			default: tgt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (pop)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_kind <= head_rec.kind;
			instr_offset <= head_rec.start;
			first_op <= head_rec.first_op;
			second_op <= head_rec.second_op;
			instr_length <= 32'(len);
			jump_target <= 32'(tgt);
			unsafe_seen <= head_rec.unsafe;
			body_end <= head_rec.last;
			fail_code <= head_rec.fail;
		end
	end

endmodule

@@ bench/cid_checker.sv @@
module cid_checker import cid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  code_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  item_kind,
	input  logic [31:0] instr_offset,
	input  logic [7:0]  first_op,
	input  logic [7:0]  second_op,
	input  logic [31:0] instr_length,
	input  logic [31:0] jump_target,
	input  logic        unsafe_seen,
	input  logic        body_end,
	input  logic [1:0]  fail_code,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] offset;
		logic [7:0]  op1;
		logic [7:0]  op2;
		logic [31:0] length;
		logic [31:0] target;
		logic        unsafe;
		logic        last;
		logic [1:0]  fail;
	} decoded_t;

	decoded_t boundary_q[$];

	logic [31:0] size_r, pos_r, start_r, accum_r, sw_left_r, sw_base_r;
	logic [2:0]  phase_r;
	logic [3:0]  opnd_left_r;
	logic [7:0]  op1_r, op2_r;
	logic [1:0]  err_r;
	logic        unsafe_r;

	// operand byte count of a one-byte opcode, -1 when undefined
	function automatic int oplen1(input logic [7:0] op);
		if (op <= 8'h0D || (op >= 8'h14 && op <= 8'h1E) || op == 8'h25 || op == 8'h26 ||
				op == 8'h2A || (op >= 8'h46 && op <= 8'h6E) || op == 8'h76 || op == 8'h7A ||
				(op >= 8'h82 && op <= 8'h8B) || op == 8'h8E || (op >= 8'h90 && op <= 8'hA2) ||
				(op >= 8'hB3 && op <= 8'hBA) || op == 8'hC3 || op == 8'hCB ||
				(op >= 8'hD1 && op <= 8'hDC) || op == 8'hDF || op == 8'hE0)
			return 0;
		if ((op >= 8'h0E && op <= 8'h13) || op == 8'h1F || (op >= 8'h2B && op <= 8'h37) ||
				op == 8'hDE)
			return 1;
		if (op == 8'h20 || op == 8'h22 || op == 8'h27 || op == 8'h28 || op == 8'h29 ||
				(op >= 8'h38 && op <= 8'h44) || (op >= 8'h6F && op <= 8'h75) || op == 8'h79 ||
				(op >= 8'h7B && op <= 8'h81) || op == 8'h8C || op == 8'h8D || op == 8'h8F ||
				(op >= 8'hA3 && op <= 8'hA5) || op == 8'hC2 || op == 8'hC6 || op == 8'hD0 ||
				op == 8'hDD)
			return 4;
		if (op == 8'h21 || op == 8'h23)
			return 8;
		return -1;
	endfunction

	function automatic int oplen2(input logic [7:0] op);
		if (op <= 8'h05 || op == 8'h0F || op == 8'h11 || op == 8'h13 || op == 8'h14 ||
				op == 8'h17 || op == 8'h18 || op == 8'h1A || op == 8'h1D || op == 8'h1E)
			return 0;
		if (op == 8'h12 || op == 8'h19)
			return 1;
		if (op >= 8'h09 && op <= 8'h0E)
			return 2;
		if (op == 8'h06 || op == 8'h07 || op == 8'h15 || op == 8'h16 || op == 8'h1C)
			return 4;
		return -1;
	endfunction

	// fields of a completed instruction other than a switch
	function automatic decoded_t complete_instr();
		decoded_t d;
		logic [31:0] rel;
		d = '{default: '0};
		d.offset = start_r;
		d.op1 = op1_r;
		d.op2 = op2_r;
		if (op1_r == OP_PREFIX) begin
			d.kind = KIND_TWO_BYTE;
			d.length = 32'(2 + oplen2(op2_r));
		end else begin
			d.length = 32'(1 + oplen1(op1_r));
			if ((op1_r >= 8'h2B && op1_r <= 8'h37) || op1_r == 8'hDE) begin
				rel = {{24{accum_r[31]}}, accum_r[31:24]};
				d.kind = KIND_SHORT_BR;
				d.target = start_r + 32'd2 + rel;
			end else if ((op1_r >= 8'h38 && op1_r <= 8'h44) || op1_r == 8'hDD) begin
				d.kind = KIND_LONG_BR;
				d.target = start_r + 32'd5 + accum_r;
			end else begin
				d.kind = (op1_r == OP_RET) ? KIND_RET : KIND_PLAIN;
			end
		end
		return d;
	endfunction

	task automatic decode_word(input logic [7:0] b);
		logic [63:0] sz, pos, base;
		logic        last, have;
		int          ol;
		decoded_t    d;
		sz = {32'd0, size_r};
		pos = {32'd0, pos_r};
		have = 0;
		d = '{default: '0};
		if (pos >= sz)
			return;
		last = (pos + 1 == sz);
		pos_r = pos_r + 32'd1;
		case (phase_r)
			PH_OPCODE: begin
				start_r = pos[31:0];
				op1_r = b;
				op2_r = '0;
				accum_r = '0;
				if (b == OP_PREFIX) begin
					if (pos + 2 > sz) begin err_r = FAIL_TRUNCATED; phase_r = PH_DEAD; end
					else phase_r = PH_SECOND;
				end else if (b == OP_SWITCH) begin
					if (pos + 5 > sz) begin err_r = FAIL_TRUNCATED; phase_r = PH_DEAD; end
					else begin phase_r = PH_SWCOUNT; opnd_left_r = 4; end
				end else begin
					ol = oplen1(b);
					if (ol < 0) begin
						err_r = FAIL_UNKNOWN;
						phase_r = PH_DEAD;
					end else begin
						if (b == OP_JMP)
							unsafe_r = 1;
						if (pos + 1 + 64'(ol) > sz) begin
							err_r = FAIL_TRUNCATED;
							phase_r = PH_DEAD;
						end else if (ol == 0) begin
							d = complete_instr();
							have = 1;
						end else begin
							phase_r = PH_OPERAND;
							opnd_left_r = 4'(ol);
						end
					end
				end
			end
			PH_SECOND: begin
				op2_r = b;
				ol = oplen2(b);
				if (ol < 0) begin
					err_r = FAIL_UNKNOWN;
					phase_r = PH_DEAD;
				end else begin
					if (b == OP2_TAIL || b == OP2_LOCALLOC)
						unsafe_r = 1;
					if ({32'd0, start_r} + 2 + 64'(ol) > sz) begin
						err_r = FAIL_TRUNCATED;
						phase_r = PH_DEAD;
					end else if (ol == 0) begin
						d = complete_instr();
						have = 1;
						phase_r = PH_OPCODE;
					end else begin
						phase_r = PH_OPERAND;
						opnd_left_r = 4'(ol);
					end
				end
			end
			PH_OPERAND: begin
				accum_r = {b, accum_r[31:8]};
				opnd_left_r = opnd_left_r - 4'd1;
				if (opnd_left_r == 0) begin
					d = complete_instr();
					have = 1;
					phase_r = PH_OPCODE;
				end
			end
			PH_SWCOUNT: begin
				accum_r = {b, accum_r[31:8]};
				opnd_left_r = opnd_left_r - 4'd1;
				if (opnd_left_r == 0) begin
					// no wrap in the table length check
					base = {32'd0, start_r} + 5 + 4 * {32'd0, accum_r};
					if (base > sz) begin
						err_r = FAIL_TRUNCATED;
						phase_r = PH_DEAD;
					end else begin
						sw_left_r = accum_r;
						sw_base_r = base[31:0];
						d.kind = KIND_SW_HDR;
						d.offset = start_r;
						d.op1 = op1_r;
						d.length = sw_base_r - start_r;
						have = 1;
						accum_r = '0;
						if (sw_left_r == 0) phase_r = PH_OPCODE;
						else begin phase_r = PH_SWTARGET; opnd_left_r = 4; end
					end
				end
			end
			PH_SWTARGET: begin
				accum_r = {b, accum_r[31:8]};
				opnd_left_r = opnd_left_r - 4'd1;
				if (opnd_left_r == 0) begin
					d.kind = KIND_SW_TGT;
					d.offset = start_r;
					d.op1 = op1_r;
					d.length = sw_base_r - start_r;
					d.target = sw_base_r + accum_r;
					have = 1;
					accum_r = '0;
					sw_left_r = sw_left_r - 32'd1;
					if (sw_left_r == 0) phase_r = PH_OPCODE;
					else opnd_left_r = 4;
				end
			end
			default: ;
		endcase
		if (last && phase_r != PH_OPCODE && phase_r != PH_DEAD) begin
			err_r = FAIL_TRUNCATED;
			phase_r = PH_DEAD;
		end
		if (!have && !last)
			return;
		if (!have) begin
			d = '{default: '0};
			d.kind = KIND_STATUS;
		end
		d.unsafe = unsafe_r;
		d.last = last;
		d.fail = last ? err_r : FAIL_NONE;
		boundary_q = {boundary_q, d};
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = boundary_q.size();

	always @(posedge clk or negedge arst_n) begin
		decoded_t e;
		if (!arst_n) begin
			size_r = '0; pos_r = '0; start_r = '0; accum_r = '0;
			sw_left_r = '0; sw_base_r = '0; phase_r = PH_OPCODE; opnd_left_r = '0;
			op1_r = '0; op2_r = '0; err_r = FAIL_NONE; unsafe_r = 0;
			boundary_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (boundary_q.size() == 0) begin
					report("unexpected word, offset", instr_offset, '0);
				end else begin
					e = boundary_q.pop_front();
					if (item_kind !== e.kind) report("item_kind", 32'(item_kind), 32'(e.kind));
					if (instr_offset !== e.offset) report("instr_offset", instr_offset, e.offset);
					if (first_op !== e.op1) report("first_op", 32'(first_op), 32'(e.op1));
					if (second_op !== e.op2) report("second_op", 32'(second_op), 32'(e.op2));
					if (instr_length !== e.length)
						report("instr_length", instr_length, e.length);
					if (jump_target !== e.target) report("jump_target", jump_target, e.target);
					if (unsafe_seen !== e.unsafe)
						report("unsafe_seen", 32'(unsafe_seen), 32'(e.unsafe));
					if (body_end !== e.last) report("body_end", 32'(body_end), 32'(e.last));
					if (fail_code !== e.fail) report("fail_code", 32'(fail_code), 32'(e.fail));
				end
			end
			// a size written at this edge applies from the next word
			if (in_valid && !in_stall)
				decode_word(code_byte);
			if (cfg_wr_en)
				size_r = cfg_wr_data;
		end
	end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cid_pkg::*;

	logic        clk, arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        in_valid, in_stall;
	logic [7:0]  code_byte;
	logic        out_valid, out_stall;
	logic [2:0]  item_kind;
	logic [31:0] instr_offset, instr_length, jump_target;
	logic [7:0]  first_op, second_op;
	logic        unsafe_seen, body_end;
	logic [1:0]  fail_code;
	int          fail_count, pending;

	logic [7:0]  code_q[$];
	logic [31:0] base;
	bit          calm, hold_once;
	int          sent, stall_left;

	cil_instruction_boundary_decoder_unit i_dut (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall, .code_byte,
		.out_valid, .out_stall, .item_kind, .instr_offset, .first_op, .second_op,
		.instr_length, .jump_target, .unsafe_seen, .body_end, .fail_code
	);

	cid_checker u_chk (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall, .code_byte,
		.out_valid, .out_stall, .item_kind, .instr_offset, .first_op, .second_op,
		.instr_length, .jump_target, .unsafe_seen, .body_end, .fail_code,
		.fail_count, .pending
	);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// receiver stalls, in bursts
	always @(negedge clk) begin
		if (!arst_n || calm) begin
			out_stall <= 0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 0;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: stall_left <= $urandom_range(1, 3);
				5: stall_left <= $urandom_range(10, 40);
				default: stall_left <= 0;
			endcase
		end
	end

	task automatic send_word(input logic [7:0] b);
		int g;
		bit st;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		code_byte <= b;
		do begin
			#1 st = in_stall;
			@(posedge clk);
			@(negedge clk);
		end while (st);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_size(input logic [31:0] v);
		in_valid <= 0;
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 0;
		@(negedge clk);
	endtask

	task automatic add_instr();
		logic [7:0] op;
		int n, r;
		r = $urandom_range(0, 99);
		if (r < 65 || (r >= 90 && $urandom_range(0, 1) == 0)) begin
			if (r < 65) begin
				do op = 8'($urandom_range(0, 255)); while (u_chk.oplen1(op) < 0);
			end else begin
				op = $urandom_range(0, 1) ? OP_RET : OP_JMP;
			end
			code_q = {code_q, op};
			repeat (u_chk.oplen1(op)) code_q = {code_q, 8'($urandom_range(0, 255))};
		end else if (r < 80 || r >= 90) begin
			if (r < 80) begin
				do op = 8'($urandom_range(0, 31)); while (u_chk.oplen2(op) < 0);
			end else begin
				op = $urandom_range(0, 1) ? OP2_TAIL : OP2_LOCALLOC;
			end
			code_q = {code_q, OP_PREFIX};
			code_q = {code_q, op};
			repeat (u_chk.oplen2(op)) code_q = {code_q, 8'($urandom_range(0, 255))};
		end else begin
			n = $urandom_range(0, 3);
			code_q = {code_q, OP_SWITCH};
			code_q = {code_q, 8'(n)};
			repeat (3) code_q = {code_q, 8'h00};
			repeat (4 * n) code_q = {code_q, 8'($urandom_range(0, 255))};
		end
	endtask

	// one body: set its size, stream it, then drain
	task automatic send_body(input int extra);
		int i;
		write_size(base + 32'(code_q.size()));
		for (i = 0; i < code_q.size(); i++) begin
			if (hold_once && sent > 600 && i == code_q.size() / 2) begin
				hold_once = 0;
				in_valid <= 0;
				while (pending != 0) @(negedge clk);
				@(negedge clk);
			end
			send_word(code_q[i]);
		end
		base = base + 32'(code_q.size());
		repeat (extra) send_word(8'($urandom_range(0, 255)));
		settle();
	endtask

	initial begin
		int n, k;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		in_valid = 0;
		code_byte = '0;
		out_stall = 0;
		calm = 0;
		hold_once = 1;
		sent = 0;
		base = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// empty body: every word is dropped
		write_size('0);
		repeat (3) send_word(8'($urandom_range(0, 255)));
		settle();

		code_q = '{8'h00, 8'hE0, OP_RET, OP_JMP, 8'h01, 8'h02, 8'h03, 8'h04,
			8'h2B, 8'h80, 8'h2B, 8'h7F, 8'h38, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hDD, 8'h00, 8'h00, 8'h00, 8'h80, OP_PREFIX, OP2_TAIL, OP_PREFIX, OP2_LOCALLOC,
			OP_PREFIX, 8'h1E, OP_PREFIX, 8'h09, 8'hAA, 8'h55, OP_SWITCH, 8'h00, 8'h00,
			8'h00, 8'h00, OP_SWITCH, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h21, 8'hFF, 8'h00, 8'hFF, 8'h00,
			8'hFF, 8'h00, 8'hFF, 8'h00};
		send_body(0);

		while (sent < 1300) begin
			calm = ($urandom_range(0, 9) == 0);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
			code_q.delete();
			while (code_q.size() < n) add_instr();
			send_body(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			if (sent > 700 && sent < 760) begin
				// largest size, then end the body with a second write
				calm = 0;
				write_size('1);
				code_q.delete();
				while (code_q.size() < 30) add_instr();
				foreach (code_q[i]) send_word(code_q[i]);
				k = code_q.size();
				settle();
				code_q.delete();
				while (code_q.size() < 10) add_instr();
				write_size(base + 32'(k + code_q.size()));
				foreach (code_q[i]) send_word(code_q[i]);
				base = base + 32'(k + code_q.size());
				settle();
			end
		end
		calm = 0;

		// an error leaves the decoder dead, so only one kind per run
		case ($urandom_range(0, 5))
			0: code_q = '{8'h00, 8'h24, 8'hFF, 8'h00};
			1: code_q = '{8'h20, 8'h01, 8'h02};
			2: code_q = '{8'h00, OP_PREFIX};
			3: code_q = '{OP_SWITCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
			4: code_q = '{OP_PREFIX, 8'h08, 8'h00, 8'h00};
			default: begin
				// body shrinks while an operand is still due
				write_size(base + 32'd100);
				send_word(8'h20);
				send_word(8'h11);
				send_word(8'h22);
				settle();
				write_size(base + 32'd4);
				send_word(8'h33);
				base = base + 32'd4;
				settle();
				code_q = '{8'h00};
			end
		endcase
		send_body(0);
		repeat (3) begin
			code_q.delete();
			repeat ($urandom_range(1, 6)) code_q = {code_q, 8'($urandom_range(0, 255))};
			send_body(0);
		end

		settle();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ cil_instruction_boundary_decoder_unit.f @@
src/cid_pkg.sv
src/cid_front.sv
src/cid_queue.sv
src/cid_back.sv
src/cil_instruction_boundary_decoder_unit.sv
bench/cid_checker.sv
bench/tb_top.sv
